/* rtl/core/sr_pkg.sv */
package sr_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int CUM_W         = 22;
   localparam int PROD_W        = CUM_W + CNT_W;

   typedef struct packed {
      logic [15:0] weight;
      logic [15:0] offset;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [5:0] ancestor_index;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [CUM_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

endpackage

/* rtl/core/sr_cum_ram.sv */
module sr_cum_ram (
   input  logic                        clock,
   input  sr_pkg::ram_req_type         ram_req,
   output logic [sr_pkg::CUM_W-1:0]    rd_data
);
   import sr_pkg::*;

   logic [CUM_W-1:0] mem [MAX_PARTICLES];
   logic [CUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sr_ctrl.sv */
module sr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sr_pkg::req_type             req_data,
   output sr_pkg::ram_req_type         ram_req,
   input  logic [sr_pkg::CUM_W-1:0]    rd_data,
   output sr_pkg::emit_type            emit,
   input  logic                        emit_ready
);
   import sr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CUM_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [15:0]      u_ff, u_in;

   logic              accept;
   logic              room;
   logic [CUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   logic [CUM_W-1:0]  target;
   logic              advance;
   logic              final_slot;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(MAX_PARTICLES));
   assign sum       = total_ff + CUM_W'(req_data.weight);

   // exact compare of n*C[j] against i*2^16 + u
   assign prod       = PROD_W'(n_ff) * PROD_W'(rd_data);
   assign target     = CUM_W'({i_ff, 16'b0}) | CUM_W'(u_ff);
   assign advance    = ((CNT_W'(j_ff) + 1'b1) < n_ff) && (prod < PROD_W'(target));
   assign final_slot = ((CNT_W'(i_ff) + 1'b1) == n_ff);

   always_comb begin
      state_in        = state_ff;
      total_in        = total_ff;
      count_in        = count_ff;
      n_in            = n_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      u_in            = u_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = count_ff[IDX_W-1:0];
      ram_req.wr_data = sum;
      emit.valid      = 1'b0;
      emit.data.ancestor_index = 6'(j_ff);
      emit.data.last_out       = final_slot;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  ram_req.wr_en = 1'b1;
                  total_in      = sum;
                  count_in      = count_ff + 1'b1;
               end
               if (req_data.last) begin
                  n_in     = room ? (count_ff + 1'b1) : count_ff;
                  u_in     = req_data.offset;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         // entry 0 may have been written in the load beat, read it afresh
         ST_FETCH: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (advance) begin
               j_in = j_ff + 1'b1;
            end else if (emit_ready) begin
               emit.valid = 1'b1;
               if (final_slot) begin
                  total_in = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ram_req.rd_addr = j_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      u_ff <= u_in;
   end

endmodule

/* rtl/core/systematic_resampler_top.sv */
// systematic resampler
// req channel: one particle weight (unsigned Q0.16) per beat. the beat with
// last set closes the set and carries the random offset u (Q0.16). up to 64
// weights are kept; further weights before last are dropped.
// rsp channel: after the last beat the block returns N ancestor indices, one
// per beat, in slot order; last_out marks the final one.
// sequence: weight beats are taken back to back while idle. after the last
// beat the block fetches entry 0, then for each slot steps the pointer until
// n*C[j] reaches the target or j is the last entry, and registers the index
// once the output register is free. the pointer moves forward only, so a run
// makes at most N - 1 pointer steps.
// req_ready is low for the whole run and rises again once the final index
// has entered the output register.
// an rsp stall holds the emit, not the pointer; the output keeps its beat.
// reset (synchronous, active high) empties the set and the output register;
// the memory contents are not cleared, only entries of the current set are
// read.
module systematic_resampler_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sr_pkg::rsp_type rsp_data
);
   import sr_pkg::*;

   ram_req_type      ram_req;
   logic [CUM_W-1:0] rd_data;
   emit_type         emit;
   logic             emit_ready;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   sr_cum_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   sr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .ram_req    (ram_req),
      .rd_data    (rd_data),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the walk only emits into a free or draining output register
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> emit_ready)
      else $error("emit into occupied output register");

   // no weight is taken while indices are being produced
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !req_ready)
      else $error("req_ready high during emit");

   // a closing beat starts a run at once
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last) |=> !req_ready)
      else $error("run did not start after last beat");

   // the final index of a run reopens the input
   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.data.last_out) |=> req_ready)
      else $error("input not reopened after final index");

endmodule

/* verif/systematic_resampler_top_test.sv */
module systematic_resampler_top_test;
   import sr_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   systematic_resampler_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // weight beats waiting to be sent and ancestor indices waiting to come back
   req_type pending_beats[$];
   rsp_type expected_indices[$];

   // shadow of the block's set state
   logic [CUM_W-1:0] cum_sums [MAX_PARTICLES];
   logic [CUM_W-1:0] weight_total = '0;
   int               weights_held = 0;

   int unsigned sender_idle_pct = 0;
   int unsigned rsp_idle_pct    = 0;

   int      errors       = 0;
   int      beats_done   = 0;
   int      sets_done    = 0;
   int      indices_seen = 0;
   req_type taken_beat;
   rsp_type want;

   function automatic void predict_ancestors(req_type beat);
      int          n;
      int          j;
      logic [63:0] target;
      rsp_type     r;
      if (weights_held < MAX_PARTICLES) begin
         weight_total           = weight_total + CUM_W'(beat.weight);
         cum_sums[weights_held] = weight_total;
         weights_held++;
      end
      if (!beat.last)
         return;
      n = weights_held;
      j = 0;
      for (int i = 0; i < n; i++) begin
         target = (64'(i) << 16) + 64'(beat.offset);
         // pointer only moves forward, stops at the last stored particle
         while (j + 1 < n && 64'(n) * 64'(cum_sums[j]) < target)
            j++;
         r.ancestor_index = 6'(j);
         r.last_out       = (i + 1 == n);
         expected_indices.insert(expected_indices.size(), r);
      end
      weight_total = '0;
      weights_held = 0;
   endfunction

   task automatic add_beat(logic [15:0] weight, logic [15:0] offset, logic last);
      req_type b;
      b.weight = weight;
      b.offset = offset;
      b.last   = last;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   // weights for a set of n: mostly normalized, sometimes short of one, sometimes raw
   task automatic make_weights(int n, ref int unsigned w[$]);
      int unsigned raw[$];
      int unsigned sum;
      int unsigned shape;
      int unsigned v;
      shape = $urandom_range(0, 99);
      sum   = 0;
      w.delete();
      for (int k = 0; k < n; k++) begin
         raw.insert(raw.size(),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1000));
         sum += raw[k];
      end
      for (int k = 0; k < n; k++) begin
         if (shape < 70)
            v = (sum == 0) ? 65536 / n : raw[k] * 65536 / sum;
         else if (shape < 85)
            v = $urandom_range(0, 32768 / n);
         else
            v = $urandom_range(0, 65535);
         w.insert(w.size(), (v > 65535) ? 65535 : v);
      end
   endtask

   task automatic add_random_set(int n);
      int unsigned w[$];
      make_weights(n, w);
      for (int k = 0; k < n; k++)
         add_beat(16'(w[k]), 16'($urandom_range(0, 65535)), k == n - 1);
   endtask

   task automatic add_random_sets(int beat_budget);
      int added;
      int n;
      added = 0;
      while (added < beat_budget) begin
         n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
         add_random_set(n);
         added += n;
      end
   endtask

   // full store, then dropped beats, the last one dropped too
   task automatic add_overflow_set();
      int unsigned w[$];
      int          extra;
      make_weights(MAX_PARTICLES, w);
      for (int k = 0; k < MAX_PARTICLES; k++)
         add_beat(16'(w[k]), 16'($urandom_range(0, 65535)), 1'b0);
      extra = $urandom_range(0, 2);
      for (int k = 0; k < extra; k++)
         add_beat(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
      add_beat(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
   endtask

   task automatic wait_sent();
      while (pending_beats.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken_beat = pending_beats.pop_front();
            predict_ancestors(taken_beat);
            beats_done++;
            if (taken_beat.last)
               sets_done++;
         end
         // a beat not yet taken stays on the bus unchanged
         if (!(req_valid && !req_ready)) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            indices_seen++;
            if (expected_indices.size() == 0) begin
               $error("unexpected beat: ancestor_index %0d last_out %0b",
                      rsp_data.ancestor_index, rsp_data.last_out);
               errors++;
            end else begin
               want = expected_indices.pop_front();
               if (rsp_data.ancestor_index !== want.ancestor_index) begin
                  $error("ancestor_index: expected %0d, got %0d",
                         want.ancestor_index, rsp_data.ancestor_index);
                  errors++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 23;
      rsp_idle_pct    = 56;
      // single particle at both extremes
      add_beat(16'h0000, 16'h0000, 1'b1);
      add_beat(16'hffff, 16'hffff, 1'b1);
      // equal weights, with offset 0 the targets land exactly on the cumulative sums
      for (int k = 0; k < 4; k++)
         add_beat(16'h4000, 16'h0000, k == 3);
      for (int k = 0; k < 4; k++)
         add_beat(16'h4000, 16'hffff, k == 3);
      // sum far short of one, pointer saturates
      for (int k = 0; k < 3; k++)
         add_beat(16'd100, 16'hffff, k == 2);
      // zero weights around one heavy particle
      add_beat(16'h0000, 16'h1234, 1'b0);
      add_beat(16'hffff, 16'h0000, 1'b0);
      add_beat(16'h0000, 16'hffff, 1'b0);
      add_beat(16'h0000, 16'h8000, 1'b1);
      // sum well above one
      add_beat(16'hffff, 16'hffff, 1'b0);
      add_beat(16'hffff, 16'h0000, 1'b1);
      add_random_sets(30);
      wait_sent();

      sender_idle_pct = 56;
      rsp_idle_pct    = 23;
      add_overflow_set();
      add_random_sets(5);
      wait_sent();

      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      add_random_sets(30);
      wait_sent();

      while (expected_indices.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);

      $display("resampled %0d sets from %0d weight beats, %0d ancestor indices checked",
               sets_done, beats_done, indices_seen);
      if (errors == 0)
         $display("systematic_resampler_top_test OK");
      else
         $display("systematic_resampler_top_test NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("systematic_resampler_top_test NOT OK");
      $finish;
   end

endmodule

/* systematic_resampler_top.f */
rtl/core/sr_pkg.sv
rtl/core/sr_cum_ram.sv
rtl/core/sr_ctrl.sv
rtl/core/systematic_resampler_top.sv
verif/systematic_resampler_top_test.sv
